// File: rtl/core/epmix_pkg.sv
`default_nettype none

package epmix_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = 6;
  localparam int WORD_W     = 32;
  localparam int ROT_W      = 5;
  localparam int MODE_W     = 2;
  localparam int UPC_W      = 4;

  localparam logic [MODE_W-1:0] MODE_MIX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  localparam logic [IDX_W-1:0] TAP_0    = 6'd52;
  localparam logic [IDX_W-1:0] TAP_1    = 6'd39;
  localparam logic [IDX_W-1:0] TAP_2    = 6'd26;
  localparam logic [IDX_W-1:0] TAP_3    = 6'd14;
  localparam logic [ROT_W-1:0] ROT_STEP = 5'd7;
  localparam logic [ROT_W-1:0] ROT_MAX  = 5'd31;

  localparam logic [WORD_W-1:0] TWIST_TAB [8] = '{
    32'h00000000, 32'h3b6e20c8, 32'h76dc4190, 32'h4db26158,
    32'hedb88320, 32'hd6d6a3e8, 32'h9b64c2b0, 32'ha00ae278
  };

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] word_x;
    logic [WORD_W-1:0] word_y;
    logic [IDX_W-1:0]  word_index;
  } epmix_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] low_word;
    logic [WORD_W-1:0] high_word;
    logic [IDX_W-1:0]  slot;
  } epmix_out_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_ROT,
    UOP_XOR,
    UOP_TWX,
    UOP_TWY,
    UOP_RDOUT,
    UOP_WRIDX
  } uop_t;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_END
  } useq_t;

  typedef struct packed {
    logic             use_idx;
    logic [IDX_W-1:0] off_a;
    logic [IDX_W-1:0] off_b;
    uop_t             op;
    useq_t            seq;
  } ucode_t;

  localparam logic [UPC_W-1:0] UPC_MIX   = 4'd0;
  localparam logic [UPC_W-1:0] UPC_READ  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_WRITE = 4'd9;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t uw;
    case (upc)
      4'd0:    uw = '{1'b0, TAP_0, TAP_0 + 6'd1, UOP_ROT, SEQ_NEXT};
      4'd1:    uw = '{1'b0, TAP_1, TAP_1 + 6'd1, UOP_XOR, SEQ_NEXT};
      4'd2:    uw = '{1'b0, TAP_2, TAP_2 + 6'd1, UOP_XOR, SEQ_NEXT};
      4'd3:    uw = '{1'b0, TAP_3, TAP_3 + 6'd1, UOP_XOR, SEQ_NEXT};
      4'd4:    uw = '{1'b0, 6'd2, 6'd1, UOP_XOR, SEQ_NEXT};
      4'd5:    uw = '{1'b0, 6'd0, 6'd0, UOP_TWX, SEQ_NEXT};
      4'd6:    uw = '{1'b0, 6'd0, 6'd0, UOP_TWY, SEQ_END};
      4'd7:    uw = '{1'b1, 6'd0, 6'd0, UOP_NOP, SEQ_NEXT};
      4'd8:    uw = '{1'b1, 6'd0, 6'd0, UOP_RDOUT, SEQ_END};
      4'd9:    uw = '{1'b1, 6'd0, 6'd0, UOP_WRIDX, SEQ_END};
      default: uw = '{1'b0, 6'd0, 6'd0, UOP_NOP, SEQ_END};
    endcase
    return uw;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] w,
                                             input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] t;
    t = {w, w} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] w);
    return (w >> 3) ^ TWIST_TAB[w[2:0]];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/epmix_pool.sv
`default_nettype none

module epmix_pool #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // Entries never written read as zero, which matches the cleared pool.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= vld_r[rd_addr_a] ? mem_r[rd_addr_a] : '0;
    rd_b_r <= vld_r[rd_addr_b] ? mem_r[rd_addr_b] : '0;
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

// File: rtl/core/entropy_pool_twisted_gfsr_mix_core.sv
// Entropy pool mixer with a 64-word pool of 32-bit words.
// The input channel (in_valid, in_ready, in_beat) carries one beat per
// operation: mix two words, read a pool word or write a pool word.
// The result channel (out_valid, out_ready, out_beat) returns one beat
// per mix, read or write; a beat with the unused mode code is taken and
// dropped without a result.
// A small microcode program steps a datapath that reads the pool through
// two registered read ports and writes it through one port. A mix takes
// seven steps. A new beat is taken only after the final step of the
// previous operation has run. The input is ready again as soon as a
// result is placed in the output register, so one new operation can
// run while a result waits. If the receiver still holds off the
// previous result, the final step of the program waits and nothing is
// lost.
// Reset clears the insert position, the rotate amount and the pool
// valid bits at once, so the pool reads as all zeros with no clearing
// pass.
`default_nettype none

module entropy_pool_twisted_gfsr_mix_core #(
  parameter int POOL_DEPTH = epmix_pkg::POOL_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire epmix_pkg::epmix_in_t  in_beat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output epmix_pkg::epmix_out_t      out_beat
);

  import epmix_pkg::*;

  logic              busy_r, busy_nxt;
  logic [UPC_W-1:0]  upc_r, upc_nxt;
  epmix_in_t         item_r, item_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [ROT_W-1:0]  rot_r, rot_nxt;
  logic [WORD_W-1:0] acc_x_r, acc_x_nxt;
  logic [WORD_W-1:0] acc_y_r, acc_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  epmix_out_t        out_beat_r, out_beat_nxt;

  ucode_t            uw;
  logic              adv;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  addr_b;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] twx_val;
  logic [WORD_W-1:0] twy_val;
  logic [IDX_W-1:0]  p_new;
  logic [ROT_W-1:0]  r_new;

  epmix_pool #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (WORD_W)
  ) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign uw       = ucode_rom(upc_r);
  assign in_ready = !busy_r;
  assign adv      = busy_r && ((uw.seq == SEQ_NEXT) || !out_valid_r || out_ready);
  assign addr_a   = uw.use_idx ? item_r.word_index : pos_r + uw.off_a;
  assign addr_b   = pos_r + uw.off_b;
  assign twx_val  = twist(acc_x_r ^ rd_a ^ rd_b);
  assign twy_val  = twist(acc_y_r ^ acc_x_r ^ rd_a);
  assign p_new    = (pos_r - IDX_W'(2)) & ~IDX_W'(1);
  assign r_new    = rot_r + ROT_STEP + ((p_new == '0) ? ROT_STEP : '0);

  always_comb begin
    busy_nxt      = busy_r;
    upc_nxt       = upc_r;
    item_nxt      = item_r;
    pos_nxt       = pos_r;
    rot_nxt       = rot_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_beat_nxt  = out_beat_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = twx_val;

    if (in_valid && in_ready) begin
      item_nxt = in_beat;
      case (in_beat.mode)
        MODE_MIX: begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_MIX;
          pos_nxt  = p_new;
          rot_nxt  = r_new & ROT_MAX;
        end
        MODE_READ: begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_READ;
        end
        MODE_WRITE: begin
          busy_nxt = 1'b1;
          upc_nxt  = UPC_WRITE;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end

    if (adv) begin
      upc_nxt = upc_r + UPC_W'(1);
      case (uw.op)
        UOP_ROT: begin
          acc_x_nxt = rotl(item_r.word_x, rot_r);
          acc_y_nxt = rotl(item_r.word_y, rot_r);
        end
        UOP_XOR: begin
          acc_y_nxt = acc_y_r ^ rd_a;
          acc_x_nxt = acc_x_r ^ rd_b;
        end
        UOP_TWX: begin
          acc_x_nxt = twx_val;
          wr_en     = 1'b1;
          wr_addr   = pos_r + IDX_W'(1);
          wr_data   = twx_val;
        end
        UOP_TWY: begin
          acc_y_nxt    = twy_val;
          wr_en        = 1'b1;
          wr_addr      = pos_r;
          wr_data      = twy_val;
          out_beat_nxt = '{twy_val, acc_x_r, pos_r};
        end
        UOP_RDOUT: begin
          out_beat_nxt = '{rd_a, '0, item_r.word_index};
        end
        UOP_WRIDX: begin
          wr_en        = 1'b1;
          wr_addr      = item_r.word_index;
          wr_data      = item_r.word_x;
          out_beat_nxt = '{item_r.word_x, '0, item_r.word_index};
        end
        default: begin
        end
      endcase
      if (uw.seq == SEQ_END) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= UPC_MIX;
      pos_r       <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      pos_r       <= pos_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    acc_x_r    <= acc_x_nxt;
    acc_y_r    <= acc_y_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

// File: rtl/core/epmix_checker.sv
`default_nettype none

module epmix_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire epmix_pkg::epmix_in_t  in_beat,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire epmix_pkg::epmix_out_t out_beat
);

  import epmix_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_beat)))
    else $error("stalled result beat changed");

  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_beat.mode != MODE_NONE)) |=> !in_ready)
    else $error("input ready while an operation runs");

  a_write_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_beat.mode == MODE_WRITE) && !out_valid)
    |=> ##1 (out_valid && (out_beat.low_word == $past(in_beat.word_x, 2))
             && (out_beat.high_word == '0)
             && (out_beat.slot == $past(in_beat.word_index, 2))))
    else $error("write result does not echo the written word");

endmodule

bind entropy_pool_twisted_gfsr_mix_core epmix_checker u_epmix_checker (.*);

`default_nettype wire

// File: verif/entropy_pool_twisted_gfsr_mix_core_test.sv
`default_nettype none

module entropy_pool_twisted_gfsr_mix_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import epmix_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int IDLE_PCT      = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int STEADY_ITEMS  = 150;
  localparam int BACKLOG_ITEMS = 24;
  localparam int RANDOM_ITEMS  = 720;

  localparam logic [3:0][IDX_W-1:0] MIX_TAPS = {TAP_3, TAP_2, TAP_1, TAP_0};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  epmix_in_t  in_beat;
  logic       out_valid;
  logic       out_ready;
  epmix_out_t out_beat;

  logic [WORD_W-1:0] shadow_pool [POOL_DEPTH];
  logic [IDX_W-1:0]  shadow_pos;
  logic [ROT_W-1:0]  shadow_rot;

  epmix_out_t pool_results_due [$];
  int         mismatch_count;
  int         idle_cycles;
  bit         steady_mode;
  bit         hold_request;

  entropy_pool_twisted_gfsr_mix_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rotate_word(input logic [WORD_W-1:0] w,
                                                    input logic [ROT_W-1:0] n);
    if (n == '0) begin
      return w;
    end
    return (w << n) | (w >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] w);
    return (w >> 3) ^ TWIST_TAB[w[2:0]];
  endfunction

  function automatic epmix_out_t apply_pool_op(input epmix_in_t b);
    epmix_out_t        res;
    logic [IDX_W-1:0]  p;
    logic [IDX_W-1:0]  t;
    logic [IDX_W-1:0]  t1;
    logic [IDX_W-1:0]  p1;
    logic [IDX_W-1:0]  p2;
    logic [ROT_W-1:0]  r;
    logic [WORD_W-1:0] wx;
    logic [WORD_W-1:0] wy;
    res = '0;
    case (b.mode)
      MODE_MIX: begin
        p = (shadow_pos - 6'd2) & 6'h3e;
        r = shadow_rot + ROT_STEP;
        if (p == '0) begin
          r = r + ROT_STEP;
        end
        shadow_pos = p;
        shadow_rot = r;
        wx = rotate_word(b.word_x, r);
        wy = rotate_word(b.word_y, r);
        for (int k = 0; k < 4; k++) begin
          t  = p + MIX_TAPS[k];
          t1 = t + 6'd1;
          wy = wy ^ shadow_pool[t];
          wx = wx ^ shadow_pool[t1];
        end
        p1 = p + 6'd1;
        p2 = p + 6'd2;
        wx = wx ^ shadow_pool[p2] ^ shadow_pool[p1];
        wx = twist_word(wx);
        shadow_pool[p1] = wx;
        wy = twist_word(wy ^ wx ^ shadow_pool[p]);
        shadow_pool[p] = wy;
        res.low_word  = wy;
        res.high_word = wx;
        res.slot      = p;
      end
      MODE_READ: begin
        res.low_word = shadow_pool[b.word_index];
        res.slot     = b.word_index;
      end
      MODE_WRITE: begin
        shadow_pool[b.word_index] = b.word_x;
        res.low_word = b.word_x;
        res.slot     = b.word_index;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic epmix_in_t make_beat(input logic [MODE_W-1:0] mode,
                                          input logic [WORD_W-1:0] wx,
                                          input logic [WORD_W-1:0] wy,
                                          input logic [IDX_W-1:0]  idx);
    epmix_in_t b;
    b.mode       = mode;
    b.word_x     = wx;
    b.word_y     = wy;
    b.word_index = idx;
    return b;
  endfunction

  function automatic epmix_in_t random_beat(input int mix_pct);
    epmix_in_t b;
    int        pick;
    b.word_x     = $urandom;
    b.word_y     = $urandom;
    b.word_index = IDX_W'($urandom_range(POOL_DEPTH - 1));
    if ($urandom_range(15) == 0) begin
      b.word_x = $urandom_range(1) ? '1 : '0;
    end
    if ($urandom_range(15) == 0) begin
      b.word_y = $urandom_range(1) ? '1 : '0;
    end
    pick = $urandom_range(99);
    if (pick < mix_pct) begin
      b.mode = MODE_MIX;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        b.mode = MODE_READ;
      end else if (pick < 85) begin
        b.mode = MODE_WRITE;
      end else begin
        b.mode = MODE_NONE;
      end
    end
    return b;
  endfunction

  task automatic send_beat(input epmix_in_t b);
    @(negedge clk);
    if (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (!in_ready);
    if (b.mode != MODE_NONE) begin
      pool_results_due.push_back(apply_pool_op(b));
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready = steady_mode || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    epmix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pool_results_due.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_beat);
        mismatch_count++;
      end else begin
        want = pool_results_due.pop_front();
        if (out_beat.low_word !== want.low_word) begin
          $display("%0t: low_word expected %h actual %h", $time, want.low_word,
                   out_beat.low_word);
          mismatch_count++;
        end
        if (out_beat.high_word !== want.high_word) begin
          $display("%0t: high_word expected %h actual %h", $time, want.high_word,
                   out_beat.high_word);
          mismatch_count++;
        end
        if (out_beat.slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_beat.slot);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    send_beat(make_beat(MODE_READ, '0, '0, 6'd0));
    send_beat(make_beat(MODE_READ, '1, '1, 6'd63));
    send_beat(make_beat(MODE_READ, '0, '1, 6'd31));
    send_beat(make_beat(MODE_MIX, '0, '0, 6'd0));
  endtask

  task automatic test_field_extremes();
    send_beat(make_beat(MODE_WRITE, '1, '0, 6'd0));
    send_beat(make_beat(MODE_WRITE, '0, '1, 6'd63));
    send_beat(make_beat(MODE_WRITE, 32'h8000_0001, '1, 6'd42));
    send_beat(make_beat(MODE_WRITE, 32'h1234_5678, 32'h5555_5555, 6'd52));
    send_beat(make_beat(MODE_READ, '0, '0, 6'd0));
    send_beat(make_beat(MODE_READ, '0, '0, 6'd63));
    send_beat(make_beat(MODE_MIX, '1, '0, 6'd63));
    send_beat(make_beat(MODE_MIX, '0, '1, 6'd0));
    send_beat(make_beat(MODE_MIX, '1, '1, 6'd21));
    send_beat(make_beat(MODE_NONE, '1, '1, 6'd63));
    send_beat(make_beat(MODE_NONE, '0, '0, 6'd0));
    send_beat(make_beat(MODE_MIX, 32'haaaa_aaaa, 32'h5555_5555, 6'd0));
    send_beat(make_beat(MODE_READ, '1, '1, 6'd56));
    send_beat(make_beat(MODE_READ, '0, '0, 6'd57));
  endtask

  task automatic test_steady_stream();
    int sent;
    epmix_in_t b;
    steady_mode = 1'b1;
    sent = 0;
    while (sent < STEADY_ITEMS) begin
      b = random_beat(85);
      send_beat(b);
      if (b.mode != MODE_NONE) begin
        sent++;
      end
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_output_backlog();
    steady_mode  = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < BACKLOG_ITEMS; i++) begin
      send_beat(random_beat(60));
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent;
    epmix_in_t b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      b = random_beat(70);
      send_beat(b);
      if (b.mode != MODE_NONE) begin
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_beat        = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    steady_mode    = 1'b0;
    hold_request   = 1'b0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      shadow_pool[i] = '0;
    end
    shadow_pos = '0;
    shadow_rot = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_field_extremes();
    test_steady_stream();
    test_output_backlog();
    test_random_traffic();

    @(negedge clk);
    in_valid = 1'b0;
    while (pool_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/epmix_pkg.sv
rtl/core/epmix_pool.sv
rtl/core/entropy_pool_twisted_gfsr_mix_core.sv
rtl/core/epmix_checker.sv
verif/entropy_pool_twisted_gfsr_mix_core_test.sv
